FILE: hw/rtl/fbpc_pkg.sv
`default_nettype none

package fbpc_pkg;

    localparam int NUM_PLANES_DEF = 6;
    localparam int COEF_W         = 32;
    localparam int POS_W          = 32;
    localparam int HALF_W         = 30;
    localparam int SUM_W          = COEF_W + 1;
    localparam int OPA_W          = SUM_W + 1;
    localparam int PROD_W         = OPA_W + COEF_W;
    localparam int ACC_W          = PROD_W + 2;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_POINT = 2'd1;
    localparam logic [1:0] ACT_CUBE  = 2'd2;

    typedef enum logic [1:0] {
        MUL_X = 2'd0,
        MUL_Y = 2'd1,
        MUL_Z = 2'd2,
        MUL_H = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     first;
        t_mul_sel mul_sel;
        logic     acc_en;
        logic     acc_d;
        logic     d_load;
    } t_mac_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/fbpc_plane_tab.sv
`default_nettype none

module fbpc_plane_tab
    import fbpc_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF,
    parameter int DEPTH      = NUM_PLANES * 4,
    parameter int IDX_W      = $clog2(DEPTH)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_wr_en,
    input  wire logic [IDX_W-1:0]         i_wr_addr,
    input  wire logic signed [COEF_W-1:0] i_wr_data,
    input  wire logic [IDX_W-1:0]         i_rd_addr,
    output logic signed [COEF_W-1:0]      o_rd_data
);

    logic signed [COEF_W-1:0] r_tab [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_tab[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_tab[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_tab[i_rd_addr];

endmodule

`default_nettype wire

FILE: hw/rtl/fbpc_mac.sv
`default_nettype none

module fbpc_mac
    import fbpc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [COEF_W-1:0] i_coef,
    input  wire logic signed [POS_W-1:0]  i_x,
    input  wire logic signed [POS_W-1:0]  i_y,
    input  wire logic signed [POS_W-1:0]  i_z,
    input  wire logic [HALF_W-1:0]        i_h,
    output logic                          o_pass
);

    logic signed [OPA_W-1:0]  w_opa;
    logic signed [COEF_W-1:0] w_opb;
    logic signed [PROD_W-1:0] w_prod;
    logic [COEF_W-1:0]        w_abs;
    logic signed [ACC_W-1:0]  w_addend;

    logic signed [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]         r_sum;
    logic signed [COEF_W-1:0] r_d;
    logic signed [ACC_W-1:0]  r_acc;

    always_comb begin
        w_opb = i_coef;
        case (i_ctl.mul_sel)
            MUL_X:   w_opa = OPA_W'(i_x);
            MUL_Y:   w_opa = OPA_W'(i_y);
            MUL_Z:   w_opa = OPA_W'(i_z);
            default: begin
                w_opa = $signed({1'b0, r_sum});
                w_opb = $signed({{(COEF_W - HALF_W){1'b0}}, i_h});
            end
        endcase
    end

    assign w_prod   = PROD_W'(w_opa) * PROD_W'(w_opb);
    assign w_abs    = i_coef[COEF_W-1] ? COEF_W'(-i_coef) : i_coef;
    assign w_addend = i_ctl.acc_d
                    ? $signed({{(ACC_W - 2 * COEF_W){r_d[COEF_W-1]}}, r_d, {COEF_W{1'b0}}})
                    : ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_ctl.d_load) begin
            r_d <= i_coef;
        end
        if (i_ctl.first) begin
            r_sum <= SUM_W'(w_abs);
        end else if (i_ctl.mul_sel != MUL_H) begin
            r_sum <= r_sum + SUM_W'(w_abs);
        end
        if (i_ctl.first) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + w_addend;
        end
    end

    assign o_pass = !r_acc[ACC_W-1] && (r_acc != '0);

endmodule

`default_nettype wire

FILE: hw/rtl/frustum_box_point_cull_top.sv
// Plane-test culling block: a test transaction runs plane by plane on one shared
// multiply-accumulate unit (four products, the d term and a sign check per plane).
// A test stops at the first rejecting plane or after the last one. The result is
// registered from S_DONE, which holds while an earlier result is not yet taken; no
// new input or coefficient write is taken until S_IDLE is reached again. Reset clears
// the plane table to zero and empties the result register.
`default_nettype none

module frustum_box_point_cull_top
    import fbpc_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [1:0]               i_action,
    input  wire logic [2:0]               i_plane_index,
    input  wire logic [1:0]               i_coef_index,
    input  wire logic signed [COEF_W-1:0] i_coef_value,
    input  wire logic signed [POS_W-1:0]  i_pos_x,
    input  wire logic signed [POS_W-1:0]  i_pos_y,
    input  wire logic signed [POS_W-1:0]  i_pos_z,
    input  wire logic [HALF_W-1:0]        i_half_size,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic                          o_inside_res
);

    localparam int DEPTH   = NUM_PLANES * 4;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(NUM_PLANES - 1);

    localparam logic [2:0] STEP_A  = 3'd0;
    localparam logic [2:0] STEP_B  = 3'd1;
    localparam logic [2:0] STEP_C  = 3'd2;
    localparam logic [2:0] STEP_DH = 3'd3;
    localparam logic [2:0] STEP_SP = 3'd4;
    localparam logic [2:0] STEP_DD = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [2:0]           r_step, n_step;
    logic [PLANE_W-1:0]   r_plane, n_plane;
    logic                 r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_res, n_out_res;

    logic signed [POS_W-1:0] r_x, r_y, r_z;
    logic [HALF_W-1:0]       r_h;

    logic                     w_in_acc;
    logic                     w_is_test;
    logic                     w_wr_en;
    logic [IDX_W-1:0]         w_wr_addr;
    logic [IDX_W-1:0]         w_rd_addr;
    logic signed [COEF_W-1:0] w_coef;
    logic                     w_pass;
    t_mac_ctl                 w_ctl;

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_is_test    = (i_action == ACT_POINT) || (i_action == ACT_CUBE);
    assign w_wr_en      = w_in_acc && (i_action == ACT_WRITE)
                       && (32'(i_plane_index) < NUM_PLANES);
    assign w_wr_addr    = IDX_W'(32'(i_plane_index) * 4 + 32'(i_coef_index));
    assign w_rd_addr    = IDX_W'(32'(r_plane) * 4 + 32'(r_step[1:0]));
    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_res;

    fbpc_plane_tab #(
        .NUM_PLANES (NUM_PLANES)
    ) u_tab (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_coef_value),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_coef)
    );

    fbpc_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_coef (w_coef),
        .i_x    (r_x),
        .i_y    (r_y),
        .i_z    (r_z),
        .i_h    (r_h),
        .o_pass (w_pass)
    );

    always_comb begin
        w_ctl         = '0;
        w_ctl.mul_sel = MUL_X;
        if (r_state == S_RUN) begin
            case (r_step)
                STEP_A: w_ctl.first = 1'b1;
                STEP_B: begin
                    w_ctl.mul_sel = MUL_Y;
                    w_ctl.acc_en  = 1'b1;
                end
                STEP_C: begin
                    w_ctl.mul_sel = MUL_Z;
                    w_ctl.acc_en  = 1'b1;
                end
                STEP_DH: begin
                    w_ctl.mul_sel = MUL_H;
                    w_ctl.acc_en  = 1'b1;
                    w_ctl.d_load  = 1'b1;
                end
                STEP_SP: begin
                    w_ctl.mul_sel = MUL_H;
                    w_ctl.acc_en  = 1'b1;
                end
                STEP_DD: begin
                    w_ctl.mul_sel = MUL_H;
                    w_ctl.acc_en  = 1'b1;
                    w_ctl.acc_d   = 1'b1;
                end
                default: w_ctl.mul_sel = MUL_H;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_plane     = r_plane;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_res   = r_out_res;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_is_test) begin
                    n_state = S_RUN;
                    n_step  = STEP_A;
                    n_plane = '0;
                end
            end
            S_RUN: begin
                if (r_step == STEP_DD) begin
                    n_state = S_CHECK;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_CHECK: begin
                if (!w_pass) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else if (r_plane == LAST_PLANE) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_plane = r_plane + PLANE_W'(1);
                    n_step  = STEP_A;
                    n_state = S_RUN;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_A;
            r_plane     <= '0;
            r_res       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_res   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_plane     <= n_plane;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
            r_out_res   <= n_out_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_is_test) begin
            r_x <= i_pos_x;
            r_y <= i_pos_y;
            r_z <= i_pos_z;
            r_h <= (i_action == ACT_CUBE) ? i_half_size : '0;
        end
    end

    a_test_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_test) |=> (r_state == S_RUN && r_step == STEP_A && r_plane == '0))
        else $error("test transaction did not start at the first plane");

    a_check_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> ($past(r_state) == S_RUN && $past(r_step) == STEP_DD))
        else $error("plane check reached before all terms were summed");

    a_done_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_state == S_DONE)) |-> ($past(r_state) == S_CHECK
            && ($past(!w_pass) || $past(r_plane) == LAST_PLANE)))
        else $error("result produced before a rejection or the last plane");

endmodule

`default_nettype wire
